### design/scle_pkg.sv
`timescale 1ns / 1ps

package scle_pkg;

  localparam int unsigned ByteW               = 8;
  localparam int unsigned CountW              = 6;
  localparam int unsigned DefaultLineCapacity = 64;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindClear = 2'd1,
    KindRead  = 2'd2,
    KindNone  = 2'd3
  } kind_e;

  // Console control characters and echo bytes.
  localparam logic [ByteW-1:0] ChNul     = 8'h00;
  localparam logic [ByteW-1:0] ChEtx     = 8'h03;
  localparam logic [ByteW-1:0] ChBel     = 8'h07;
  localparam logic [ByteW-1:0] ChBs      = 8'h08;
  localparam logic [ByteW-1:0] ChLf      = 8'h0A;
  localparam logic [ByteW-1:0] ChCr      = 8'h0D;
  localparam logic [ByteW-1:0] ChNak     = 8'h15;
  localparam logic [ByteW-1:0] ChSpace   = 8'h20;
  localparam logic [ByteW-1:0] ChDel     = 8'h7F;
  localparam logic [ByteW-1:0] ChPrintLo = 8'd32;
  localparam logic [ByteW-1:0] ChPrintHi = 8'd126;

  // Number of echo bytes in a result.
  localparam logic [1:0] EchoNone  = 2'd0;
  localparam logic [1:0] EchoOne   = 2'd1;
  localparam logic [1:0] EchoTwo   = 2'd2;
  localparam logic [1:0] EchoThree = 2'd3;

endpackage

### design/scle_ram.sv
`timescale 1ns / 1ps

module scle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/serial_console_line_editor.sv
`timescale 1ns / 1ps
// Most items give their result in the output register the cycle after acceptance; a read
// and a Ctrl-U on a nonempty line pass first through the read or erase state, the read
// for the registered read port of the line store. Ctrl-U then gives one result per stored
// character, one per cycle while the sink takes them. One item is taken per cycle while
// the sink takes results; a read or erase holds the input off until its last result.
// Reset clears the fill count, the flag, the output register and the entry valid bits.

module serial_console_line_editor #(
  parameter int unsigned LINE_CAPACITY = scle_pkg::DefaultLineCapacity
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  scle_pkg::kind_e              kind_i,
  input  logic [scle_pkg::ByteW-1:0]   rx_byte_i,
  input  logic [scle_pkg::CountW-1:0]  read_index_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [1:0]                   echo_count_o,
  output logic [scle_pkg::ByteW-1:0]   echo_first_o,
  output logic [scle_pkg::ByteW-1:0]   echo_second_o,
  output logic [scle_pkg::ByteW-1:0]   echo_third_o,
  output logic                         line_ready_o,
  output logic [scle_pkg::CountW-1:0]  line_length_o,
  output logic [scle_pkg::ByteW-1:0]   read_byte_o,
  output logic                         last_of_run_o
);

  import scle_pkg::*;

  // The line store holds LINE_CAPACITY bytes; entries past it read as zero.
  localparam int unsigned AddrW = $clog2(LINE_CAPACITY);
  localparam logic [CountW:0] FillLimit = (CountW + 1)'(LINE_CAPACITY - 1);
  localparam logic [CountW:0] StoreEnd  = (CountW + 1)'(LINE_CAPACITY);

  typedef enum logic [1:0] {
    StIdle,
    StRead,
    StErase
  } state_e;

  state_e                  state_q, state_d;
  logic [CountW-1:0]       fill_q, fill_d;
  logic                    flag_q, flag_d;
  logic [LINE_CAPACITY-1:0] vld_q, vld_d;
  logic                    hit_q, hit_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  logic [1:0]              echo_count_q, echo_count_d;
  logic [ByteW-1:0]        echo_first_q, echo_first_d;
  logic [ByteW-1:0]        echo_second_q, echo_second_d;
  logic [ByteW-1:0]        echo_third_q, echo_third_d;
  logic                    line_ready_q, line_ready_d;
  logic [CountW-1:0]       line_length_q, line_length_d;
  logic [ByteW-1:0]        read_byte_q, read_byte_d;
  logic                    last_q, last_d;

  // Line store port signals.
  logic                    ram_we;
  logic [AddrW-1:0]        ram_waddr;
  logic [ByteW-1:0]        ram_wdata;
  logic                    ram_re;
  logic [AddrW-1:0]        ram_raddr;
  logic [ByteW-1:0]        ram_rdata;

  // Result assembled in this cycle.
  logic                    ld;
  logic [1:0]              ld_cnt;
  logic [ByteW-1:0]        ld_a, ld_b, ld_c, ld_rd;
  logic                    ld_last;

  logic                    out_free;
  logic                    accept;
  logic                    rd_in_range;
  logic                    printable;

  scle_ram #(
    .Width (ByteW),
    .Depth (LINE_CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // The output register frees itself when the sink takes the word, so a new item can
  // be accepted in the same cycle that the previous result leaves.
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == StIdle) && out_free;
  assign accept     = in_valid_i && in_ready_o;

  assign rd_in_range = {1'b0, read_index_i} < StoreEnd;
  assign printable   = (rx_byte_i >= ChPrintLo) && (rx_byte_i <= ChPrintHi);
  assign ram_raddr   = read_index_i[AddrW-1:0];

  always_comb begin
    state_d       = state_q;
    fill_d        = fill_q;
    flag_d        = flag_q;
    vld_d         = vld_q;
    hit_d         = hit_q;
    out_valid_d   = out_valid_q;
    echo_count_d  = echo_count_q;
    echo_first_d  = echo_first_q;
    echo_second_d = echo_second_q;
    echo_third_d  = echo_third_q;
    line_ready_d  = line_ready_q;
    line_length_d = line_length_q;
    read_byte_d   = read_byte_q;
    last_d        = last_q;

    ram_we    = 1'b0;
    ram_waddr = fill_q[AddrW-1:0];
    ram_wdata = ChNul;
    ram_re    = 1'b0;

    ld      = 1'b0;
    ld_cnt  = EchoNone;
    ld_a    = ChNul;
    ld_b    = ChNul;
    ld_c    = ChNul;
    ld_rd   = ChNul;
    ld_last = 1'b1;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          unique case (kind_i)
            KindClear: begin
              flag_d = 1'b0;
              fill_d = '0;
              ld     = 1'b1;
            end
            KindRead: begin
              // Entries never written since reset read as zero.
              ram_re  = rd_in_range;
              hit_d   = rd_in_range && vld_q[ram_raddr];
              state_d = StRead;
            end
            KindNone: begin
              ld = 1'b1;
            end
            KindByte: begin
              unique case (rx_byte_i)
                ChCr, ChLf: begin
                  // Terminate the text with a NUL; the count stays.
                  ram_we = 1'b1;
                  flag_d = 1'b1;
                  ld     = 1'b1;
                  ld_cnt = EchoTwo;
                  ld_a   = ChCr;
                  ld_b   = ChLf;
                end
                ChEtx: begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  fill_d    = '0;
                  ld        = 1'b1;
                end
                ChNak: begin
                  if (fill_q == '0) begin
                    ld = 1'b1;
                  end else begin
                    state_d = StErase;
                  end
                end
                ChBs, ChDel: begin
                  if (fill_q != '0) begin
                    fill_d = fill_q - CountW'(1);
                  end
                  ld     = 1'b1;
                  ld_cnt = EchoThree;
                  ld_a   = ChBs;
                  ld_b   = ChSpace;
                  ld_c   = ChBs;
                end
                default: begin
                  ld = 1'b1;
                  if (printable) begin
                    ld_cnt = EchoOne;
                    if ({1'b0, fill_q} < FillLimit) begin
                      ram_we    = 1'b1;
                      ram_wdata = rx_byte_i;
                      fill_d    = fill_q + CountW'(1);
                      ld_a      = rx_byte_i;
                    end else begin
                      ld_a = ChBel;
                    end
                  end
                end
              endcase
            end
          endcase
        end
      end
      StRead: begin
        // The output register was free at acceptance and nothing has loaded it since.
        ld      = 1'b1;
        ld_rd   = hit_q ? ram_rdata : ChNul;
        state_d = StIdle;
      end
      StErase: begin
        // One erase result per stored character, the last one at an empty line.
        if (out_free) begin
          fill_d  = fill_q - CountW'(1);
          ld      = 1'b1;
          ld_cnt  = EchoThree;
          ld_a    = ChBs;
          ld_b    = ChSpace;
          ld_c    = ChBs;
          ld_last = (fill_d == '0);
          if (fill_d == '0) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (ram_we) begin
      vld_d[ram_waddr] = 1'b1;
    end

    // Each result shows the flag and the count after its own step.
    if (ld) begin
      out_valid_d   = 1'b1;
      echo_count_d  = ld_cnt;
      echo_first_d  = ld_a;
      echo_second_d = ld_b;
      echo_third_d  = ld_c;
      line_ready_d  = flag_d;
      line_length_d = fill_d;
      read_byte_d   = ld_rd;
      last_d        = ld_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      fill_q        <= '0;
      flag_q        <= 1'b0;
      vld_q         <= '0;
      hit_q         <= 1'b0;
      out_valid_q   <= 1'b0;
      echo_count_q  <= EchoNone;
      echo_first_q  <= ChNul;
      echo_second_q <= ChNul;
      echo_third_q  <= ChNul;
      line_ready_q  <= 1'b0;
      line_length_q <= '0;
      read_byte_q   <= ChNul;
      last_q        <= 1'b0;
    end else begin
      state_q       <= state_d;
      fill_q        <= fill_d;
      flag_q        <= flag_d;
      vld_q         <= vld_d;
      hit_q         <= hit_d;
      out_valid_q   <= out_valid_d;
      echo_count_q  <= echo_count_d;
      echo_first_q  <= echo_first_d;
      echo_second_q <= echo_second_d;
      echo_third_q  <= echo_third_d;
      line_ready_q  <= line_ready_d;
      line_length_q <= line_length_d;
      read_byte_q   <= read_byte_d;
      last_q        <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign echo_count_o  = echo_count_q;
  assign echo_first_o  = echo_first_q;
  assign echo_second_o = echo_second_q;
  assign echo_third_o  = echo_third_q;
  assign line_ready_o  = line_ready_q;
  assign line_length_o = line_length_q;
  assign read_byte_o   = read_byte_q;
  assign last_of_run_o = last_q;

endmodule
